// ===== design/ls22_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ls22_pkg
// Shared types and constants of the 2x2 linear solver.
// ----------------------------------------------------------------------------
package ls22_pkg;

    // Port widths of the payload fields and the threshold register.
    localparam int FIELD_W  = 32;
    localparam int CFG_W    = 32;
    localparam int STATUS_W = 2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_SOLVED    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SINGULAR  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SATURATED = 2'd2;

    // Classification of one system, passed from the front end to the back end.
    typedef struct packed {
        logic singular;
        logic neg0;
        logic neg1;
    } ls22_flags_t;

endpackage : ls22_pkg
`default_nettype wire

// ===== design/ls22_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ls22_front
// Accepts systems, forms the determinant and both Cramer numerators exactly,
// and classifies each system before it is written into the queue.
// ----------------------------------------------------------------------------
module ls22_front
    import ls22_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int QW         = 3 * 2 * DATA_WIDTH + 3
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [CFG_W-1:0]   cfg_wdata,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [FIELD_W-1:0] a00,
    input  wire logic [FIELD_W-1:0] a01,
    input  wire logic [FIELD_W-1:0] a10,
    input  wire logic [FIELD_W-1:0] a11,
    input  wire logic [FIELD_W-1:0] b0,
    input  wire logic [FIELD_W-1:0] b1,
    output logic                    q_push,
    output logic [QW-1:0]           q_wdata,
    input  wire logic               q_full
);

    localparam int W  = DATA_WIDTH;
    localparam int MW = 2 * W;
    localparam int TW = (MW + 1 > CFG_W) ? MW + 1 : CFG_W;

    logic [CFG_W-1:0] min_abs_det_reg;

    logic signed [W-1:0] a00_s, a01_s, a10_s, a11_s, b0_s, b1_s;

    logic                 front_en;
    logic                 s1_valid_reg;
    logic                 s2_valid_reg;
    logic signed [MW-1:0] p_a00a11_reg, p_a01a10_reg;
    logic signed [MW-1:0] p_a11b0_reg, p_a01b1_reg;
    logic signed [MW-1:0] p_a00b1_reg, p_a10b0_reg;
    logic signed [MW:0]   det_reg, n0_reg, n1_reg;

    logic [MW:0]  det_u, n0_u, n1_u;
    logic [MW:0]  det_abs, n0_abs, n1_abs;
    ls22_flags_t  flags;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_abs_det_reg <= CFG_W'(1);
        end
        else if (cfg_we)
        begin
            min_abs_det_reg <= cfg_wdata;
        end
    end

    assign a00_s = a00[W-1:0];
    assign a01_s = a01[W-1:0];
    assign a10_s = a10[W-1:0];
    assign a11_s = a11[W-1:0];
    assign b0_s  = b0[W-1:0];
    assign b1_s  = b1[W-1:0];

    // The front end only holds when its last stage cannot drop into the queue.
    assign front_en = !s2_valid_reg || !q_full;
    assign in_stall = !front_en;
    assign q_push   = s2_valid_reg && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (front_en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (front_en)
        begin
            p_a00a11_reg <= a00_s * a11_s;
            p_a01a10_reg <= a01_s * a10_s;
            p_a11b0_reg  <= a11_s * b0_s;
            p_a01b1_reg  <= a01_s * b1_s;
            p_a00b1_reg  <= a00_s * b1_s;
            p_a10b0_reg  <= a10_s * b0_s;

            det_reg <= (MW+1)'(p_a00a11_reg) - (MW+1)'(p_a01a10_reg);
            n0_reg  <= (MW+1)'(p_a11b0_reg) - (MW+1)'(p_a01b1_reg);
            n1_reg  <= (MW+1)'(p_a00b1_reg) - (MW+1)'(p_a10b0_reg);
        end
    end

    assign det_u = det_reg;
    assign n0_u  = n0_reg;
    assign n1_u  = n1_reg;

    // The exact values never reach -2^(2W), so the magnitudes fit in 2W bits.
    assign det_abs = det_u[MW] ? (~det_u + 1'b1) : det_u;
    assign n0_abs  = n0_u[MW]  ? (~n0_u + 1'b1)  : n0_u;
    assign n1_abs  = n1_u[MW]  ? (~n1_u + 1'b1)  : n1_u;

    always_comb
    begin
        flags.singular = (TW'(det_abs) < TW'(min_abs_det_reg)) || (det_u == '0);
        flags.neg0     = n0_u[MW] ^ det_u[MW];
        flags.neg1     = n1_u[MW] ^ det_u[MW];
    end

    assign q_wdata = {flags, n0_abs[MW-1:0], n1_abs[MW-1:0], det_abs[MW-1:0]};

endmodule : ls22_front
`default_nettype wire

// ===== design/ls22_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ls22_queue
// Short flop-based FIFO between the front end and the divider back end.
// ----------------------------------------------------------------------------
module ls22_queue
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // The front end must never push into a full queue, nor the back end pop an empty one.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !empty)
        else $error("queue read while empty");

endmodule : ls22_queue
`default_nettype wire

// ===== design/ls22_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ls22_div
// Pipelined restoring divider: one quotient bit per stage, truncated toward
// zero, then clipped to the signed range and given its sign.
// ----------------------------------------------------------------------------
module ls22_div
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
)
(
    input  wire logic                    clk,
    input  wire logic                    en,
    input  wire logic [2*DATA_WIDTH-1:0] num_mag,
    input  wire logic [2*DATA_WIDTH-1:0] den_mag,
    input  wire logic                    neg,
    output logic [DATA_WIDTH-1:0]        quot,
    output logic                         sat
);

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int MW = 2 * W;
    localparam int NW = MW + F;
    localparam int RW = MW + 1;
    localparam int HW = W + F;
    localparam int EW = (HW > RW) ? HW : RW;

    localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};

    logic [NW-1:0] n_full;
    logic [EW-1:0] high_ext;
    logic [EW-1:0] den_ext;

    logic [RW-1:0] rem_reg [0:W-1];
    logic [MW-1:0] dm_reg  [0:W-1];
    logic [W-1:0]  low_reg [0:W-1];
    logic [W-1:0]  q_reg   [0:W];
    logic          neg_reg [0:W];
    logic          ovf_reg [0:W];

    logic          over_lim;
    logic [W-1:0]  mag;

    // The quotient only fits in W bits when (num << F) >> W is below the divisor.
    assign n_full   = NW'(num_mag) << F;
    assign high_ext = EW'(n_full[NW-1:W]);
    assign den_ext  = EW'(den_mag);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= high_ext[RW-1:0];
            dm_reg[0]  <= den_mag;
            low_reg[0] <= n_full[W-1:0];
            q_reg[0]   <= '0;
            neg_reg[0] <= neg;
            ovf_reg[0] <= (high_ext >= den_ext);
        end
    end

    genvar k;
    generate
        for (k = 1; k <= W; k++)
        begin : g_stage
            logic [RW-1:0] trial;
            logic          take;

            assign trial = {rem_reg[k-1][RW-2:0], low_reg[k-1][W-1]};
            assign take  = (trial >= RW'(dm_reg[k-1]));

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    q_reg[k]   <= {q_reg[k-1][W-2:0], take};
                    neg_reg[k] <= neg_reg[k-1];
                    ovf_reg[k] <= ovf_reg[k-1];
                end
            end

            if (k < W)
            begin : g_carry
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[k] <= take ? (trial - RW'(dm_reg[k-1])) : trial;
                        dm_reg[k]  <= dm_reg[k-1];
                        low_reg[k] <= {low_reg[k-1][W-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign over_lim = neg_reg[W] ? (q_reg[W] > LIM_NEG) : (q_reg[W] > LIM_POS);
    assign sat      = ovf_reg[W] || over_lim;
    assign mag      = sat ? (neg_reg[W] ? LIM_NEG : LIM_POS) : q_reg[W];
    assign quot     = neg_reg[W] ? (~mag + 1'b1) : mag;

endmodule : ls22_div
`default_nettype wire

// ===== design/ls22_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ls22_back
// Takes classified systems from the queue, runs both quotients through
// parallel divider lanes and holds each result in the output register.
// ----------------------------------------------------------------------------
module ls22_back
    import ls22_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    parameter int QW         = 3 * 2 * DATA_WIDTH + 3
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [QW-1:0]       q_rdata,
    input  wire logic                q_empty,
    output logic                     q_pop,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [FIELD_W-1:0]       x0,
    output logic [FIELD_W-1:0]       x1,
    output logic [STATUS_W-1:0]      status
);

    localparam int W  = DATA_WIDTH;
    localparam int MW = 2 * W;

    ls22_flags_t   q_flags;
    logic [MW-1:0] q_n0, q_n1, q_det;

    logic          back_en;
    logic          vld_reg  [0:W];
    logic          sing_reg [0:W];

    logic [W-1:0]  quot0, quot1;
    logic          sat0, sat1;

    logic                out_valid_reg;
    logic [FIELD_W-1:0]  x0_reg, x1_reg;
    logic [STATUS_W-1:0] status_reg;

    assign {q_flags, q_n0, q_n1, q_det} = q_rdata;

    // The whole divider pipeline moves together; it only freezes behind a
    // result that is still waiting at the output.
    assign back_en = !out_valid_reg || !out_stall;
    assign q_pop   = back_en && !q_empty;

    ls22_div #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div0 (
        .clk     (clk),
        .en      (back_en),
        .num_mag (q_n0),
        .den_mag (q_det),
        .neg     (q_flags.neg0),
        .quot    (quot0),
        .sat     (sat0)
    );

    ls22_div #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div1 (
        .clk     (clk),
        .en      (back_en),
        .num_mag (q_n1),
        .den_mag (q_det),
        .neg     (q_flags.neg1),
        .quot    (quot1),
        .sat     (sat1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= W; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (back_en)
        begin
            vld_reg[0] <= q_pop;
            for (int i = 1; i <= W; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
            out_valid_reg <= vld_reg[W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (back_en)
        begin
            sing_reg[0] <= q_flags.singular;
            for (int i = 1; i <= W; i++)
            begin
                sing_reg[i] <= sing_reg[i-1];
            end

            if (sing_reg[W])
            begin
                x0_reg     <= '0;
                x1_reg     <= '0;
                status_reg <= ST_SINGULAR;
            end
            else
            begin
                x0_reg     <= FIELD_W'(quot0);
                x1_reg     <= FIELD_W'(quot1);
                status_reg <= (sat0 || sat1) ? ST_SATURATED : ST_SOLVED;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign x0        = x0_reg;
    assign x1        = x1_reg;
    assign status    = status_reg;

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_SINGULAR) |-> (x0_reg == '0 && x1_reg == '0))
        else $error("singular result with nonzero unknowns");

    a_upper_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((x0_reg >> W) == '0 && (x1_reg >> W) == '0))
        else $error("result bits above the data width are set");

endmodule : ls22_back
`default_nettype wire

// ===== design/linear_solve_2x2.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// linear_solve_2x2
// Solves a 2x2 fixed-point system by Cramer's rule with singularity and
// saturation reporting.
// ----------------------------------------------------------------------------
//  Channel   Handshake               Payload
//  input     in_valid / in_stall     a00 a01 a10 a11 b0 b1
//  output    out_valid / out_stall   x0 x1 status
//  config    cfg_we                  cfg_wdata (min_abs_det)
//
//  One request is accepted per clock while in_stall is low; a request passes
//  through the two front stages, the queue entry, the DATA_WIDTH + 1 divider
//  stages (a set-up stage, then one that retires each quotient bit), and the
//  output register.
//  Reset clears all valid flags and the queue and sets min_abs_det to 1.
//  A stalled result freezes the divider pipeline; the front end keeps taking
//  requests until its four-entry queue fills, and only then raises in_stall.
// ----------------------------------------------------------------------------
module linear_solve_2x2
    import ls22_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [CFG_W-1:0]    cfg_wdata,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [FIELD_W-1:0]  a00,
    input  wire logic [FIELD_W-1:0]  a01,
    input  wire logic [FIELD_W-1:0]  a10,
    input  wire logic [FIELD_W-1:0]  a11,
    input  wire logic [FIELD_W-1:0]  b0,
    input  wire logic [FIELD_W-1:0]  b1,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [FIELD_W-1:0]       x0,
    output logic [FIELD_W-1:0]       x1,
    output logic [STATUS_W-1:0]      status
);

    localparam int QW    = 3 * 2 * DATA_WIDTH + $bits(ls22_flags_t);
    localparam int DEPTH = 4;

    logic          q_push;
    logic [QW-1:0] q_wdata;
    logic          q_full;
    logic          q_pop;
    logic [QW-1:0] q_rdata;
    logic          q_empty;

    ls22_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .QW         (QW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .a00       (a00),
        .a01       (a01),
        .a10       (a10),
        .a11       (a11),
        .b0        (b0),
        .b1        (b1),
        .q_push    (q_push),
        .q_wdata   (q_wdata),
        .q_full    (q_full)
    );

    ls22_queue #(
        .WIDTH (QW),
        .DEPTH (DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wdata),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rdata),
        .empty   (q_empty)
    );

    ls22_back #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .QW         (QW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_rdata   (q_rdata),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .x0        (x0),
        .x1        (x1),
        .status    (status)
    );

endmodule : linear_solve_2x2
`default_nettype wire
